// ----- hdl/svpw_pkg.sv -----
package svpw_pkg;

   localparam int PAGE_DIM_X  = 8;
   localparam int PAGE_DIM_Y  = 8;
   localparam int PAGE_DIM_Z  = 8;
   localparam int MAX_PAGES   = 64;
   localparam int PAGE_CELLS  = PAGE_DIM_X * PAGE_DIM_Y * PAGE_DIM_Z;
   localparam int TOTAL_CELLS = MAX_PAGES * PAGE_CELLS;

   localparam int COORD_W = 24;
   localparam int SCALE_W = 16;
   localparam int GRID_W  = 7;
   localparam int PROD_W  = COORD_W + SCALE_W;
   localparam int FRACI_W = 16;
   localparam int FRAC_W  = 8;
   localparam int LEVEL_W = 8;
   localparam int PAGE_W  = 6;
   localparam int CELL_W  = 9;
   localparam int SLOT_W  = $clog2(TOTAL_CELLS);
   localparam int STORE_W = 3 * FRAC_W + LEVEL_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = COORD_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_X    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_Y    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGES_Z    = 3'd6;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_CLEAR  = 9'b000000010,
      ST_MUL_X  = 9'b000000100,
      ST_MUL_Y  = 9'b000001000,
      ST_MUL_Z  = 9'b000010000,
      ST_GRID   = 9'b000100000,
      ST_PAGE_X = 9'b001000000,
      ST_LOOKUP = 9'b010000000,
      ST_WRITE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] a;
      logic [SCALE_W-1:0] b;
      logic [GRID_W-1:0]  c;
   } mul_req_type;

   // floor(255 * f / 65536)
   function automatic logic [FRAC_W-1:0] frac_quant(input logic [FRACI_W-1:0] f);
      logic [FRACI_W+FRAC_W-1:0] t;
      t = {f, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, f};
      return t[FRACI_W+FRAC_W-1:FRACI_W];
   endfunction

endpackage

// ----- hdl/svpw_mul_add.sv -----
module svpw_mul_add (
   input  svpw_pkg::mul_req_type           req,
   output logic [svpw_pkg::PROD_W-1:0]     product
);

   assign product = svpw_pkg::PROD_W'(req.a) * svpw_pkg::PROD_W'(req.b)
                  + svpw_pkg::PROD_W'(req.c);

endmodule

// ----- hdl/sparse_volume_point_writer.sv -----
// sequence: from idle a point steps through mul_x, mul_y, mul_z, grid, page_x, lookup and write;
//    points below the origin or outside the page grid drop in grid, page index overflows in lookup
// the result strobe is registered; a new point is taken only in idle; one shared multiply-add
//    runs three axis scalings and two page-index steps, then a cell memory read and write
// reset: synchronous, restores state, strobe, csr registers and page bitmap, then sweeps all
//    32768 cell-written memory entries one entry a cycle with busy high; results cannot be stalled
module sparse_volume_point_writer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [svpw_pkg::COORD_W-1:0]    req_point_x,
   input  logic signed [svpw_pkg::COORD_W-1:0]    req_point_y,
   input  logic signed [svpw_pkg::COORD_W-1:0]    req_point_z,
   input  logic        [svpw_pkg::LEVEL_W-1:0]    req_level,
   output logic                                   rsp_strobe,
   output logic        [svpw_pkg::PAGE_W-1:0]     rsp_page_number,
   output logic        [svpw_pkg::CELL_W-1:0]     rsp_cell_number,
   output logic        [svpw_pkg::FRAC_W-1:0]     rsp_frac_x,
   output logic        [svpw_pkg::FRAC_W-1:0]     rsp_frac_y,
   output logic        [svpw_pkg::FRAC_W-1:0]     rsp_frac_z,
   output logic        [svpw_pkg::LEVEL_W-1:0]    rsp_stored_level,
   output logic                                   rsp_page_was_new,
   output logic                                   rsp_overwrote,
   output logic                                   rsp_out_of_range,
   input  logic                                   csr_wen,
   input  logic        [svpw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [svpw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = svpw_pkg::COORD_W;
   localparam int FW = svpw_pkg::FRACI_W;

   svpw_pkg::state_type state_ff, state_in;

   logic signed [CW-1:0]               origin_x_ff, origin_y_ff, origin_z_ff;
   logic [svpw_pkg::SCALE_W-1:0]       scale_ff;
   logic [svpw_pkg::GRID_W-1:0]        pages_x_ff, pages_y_ff, pages_z_ff;

   logic [CW-1:0]                      diff_x_ff, diff_y_ff, diff_z_ff;
   logic [CW-1:0]                      diff_x_in, diff_y_in, diff_z_in;
   logic                               neg_ff, neg_in;
   logic [svpw_pkg::LEVEL_W-1:0]       level_ff, level_in;
   logic [CW-1:0]                      ix_ff, iy_ff, iz_ff, ix_in, iy_in, iz_in;
   logic [FW-1:0]                      fx_ff, fy_ff, fz_ff, fx_in, fy_in, fz_in;
   logic [CW-1:0]                      acc_ff, acc_in;
   logic [svpw_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [svpw_pkg::SLOT_W-1:0]        clear_cnt_ff, clear_cnt_in;
   logic [svpw_pkg::MAX_PAGES-1:0]     page_present_ff, page_present_in;
   logic                               was_new_ff, was_new_in;

   logic                               strobe_ff, strobe_in;
   logic [svpw_pkg::PAGE_W-1:0]        page_out_ff, page_out_in;
   logic [svpw_pkg::CELL_W-1:0]        cell_out_ff, cell_out_in;
   logic [svpw_pkg::FRAC_W-1:0]        frac_x_ff, frac_y_ff, frac_z_ff;
   logic [svpw_pkg::FRAC_W-1:0]        frac_x_in, frac_y_in, frac_z_in;
   logic [svpw_pkg::LEVEL_W-1:0]       level_out_ff, level_out_in;
   logic                               was_new_out_ff, was_new_out_in;
   logic                               over_ff, over_in;
   logic                               oor_ff, oor_in;

   logic                               cell_written_mem [svpw_pkg::TOTAL_CELLS];
   logic [svpw_pkg::STORE_W-1:0]       cell_store_mem [svpw_pkg::TOTAL_CELLS];
   logic                               written_rd_ff;
   logic [svpw_pkg::STORE_W-1:0]       store_rd_ff;

   svpw_pkg::mul_req_type              mul_req;
   logic [svpw_pkg::PROD_W-1:0]        product;

   logic signed [CW:0]                 dx, dy, dz;
   logic [CW-1:0]                      gx, gy, gz;
   logic [CW-1:0]                      cell_sum;
   logic                               grid_bad;
   logic [svpw_pkg::PAGE_W-1:0]        page_idx;

   svpw_mul_add u_mul_add (
      .req     (mul_req),
      .product (product)
   );

   assign dx = {req_point_x[CW-1], req_point_x} - {origin_x_ff[CW-1], origin_x_ff};
   assign dy = {req_point_y[CW-1], req_point_y} - {origin_y_ff[CW-1], origin_y_ff};
   assign dz = {req_point_z[CW-1], req_point_z} - {origin_z_ff[CW-1], origin_z_ff};

   assign gx = CW'(ix_ff / svpw_pkg::PAGE_DIM_X);
   assign gy = CW'(iy_ff / svpw_pkg::PAGE_DIM_Y);
   assign gz = CW'(iz_ff / svpw_pkg::PAGE_DIM_Z);
   assign grid_bad = neg_ff || (gx >= CW'(pages_x_ff)) || (gy >= CW'(pages_y_ff))
                     || (gz >= CW'(pages_z_ff));
   assign cell_sum = CW'(ix_ff % svpw_pkg::PAGE_DIM_X
                     + (iy_ff % svpw_pkg::PAGE_DIM_Y) * svpw_pkg::PAGE_DIM_X
                     + (iz_ff % svpw_pkg::PAGE_DIM_Z)
                       * (svpw_pkg::PAGE_DIM_X * svpw_pkg::PAGE_DIM_Y));
   assign page_idx = acc_ff[svpw_pkg::PAGE_W-1:0];

   always_comb begin
      mul_req = '{a: diff_x_ff, b: scale_ff, c: '0};
      unique case (state_ff)
         svpw_pkg::ST_MUL_Y: begin
            mul_req = '{a: diff_y_ff, b: scale_ff, c: '0};
         end
         svpw_pkg::ST_MUL_Z: begin
            mul_req = '{a: diff_z_ff, b: scale_ff, c: '0};
         end
         svpw_pkg::ST_GRID: begin
            mul_req = '{a: gz, b: svpw_pkg::SCALE_W'(pages_y_ff),
                        c: gy[svpw_pkg::GRID_W-1:0]};
         end
         svpw_pkg::ST_PAGE_X: begin
            mul_req = '{a: acc_ff, b: svpw_pkg::SCALE_W'(pages_x_ff),
                        c: gx[svpw_pkg::GRID_W-1:0]};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      diff_x_in       = diff_x_ff;
      diff_y_in       = diff_y_ff;
      diff_z_in       = diff_z_ff;
      neg_in          = neg_ff;
      level_in        = level_ff;
      ix_in           = ix_ff;
      iy_in           = iy_ff;
      iz_in           = iz_ff;
      fx_in           = fx_ff;
      fy_in           = fy_ff;
      fz_in           = fz_ff;
      acc_in          = acc_ff;
      slot_in         = slot_ff;
      clear_cnt_in    = clear_cnt_ff;
      page_present_in = page_present_ff;
      was_new_in      = was_new_ff;
      strobe_in       = 1'b0;
      page_out_in     = page_out_ff;
      cell_out_in     = cell_out_ff;
      frac_x_in       = frac_x_ff;
      frac_y_in       = frac_y_ff;
      frac_z_in       = frac_z_ff;
      level_out_in    = level_out_ff;
      was_new_out_in  = was_new_out_ff;
      over_in         = over_ff;
      oor_in          = oor_ff;
      unique case (state_ff)
         svpw_pkg::ST_IDLE: begin
            if (start) begin
               diff_x_in = dx[CW-1:0];
               diff_y_in = dy[CW-1:0];
               diff_z_in = dz[CW-1:0];
               neg_in    = dx[CW] || dy[CW] || dz[CW];
               level_in  = req_level;
               state_in  = svpw_pkg::ST_MUL_X;
            end
         end
         svpw_pkg::ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == svpw_pkg::SLOT_W'(svpw_pkg::TOTAL_CELLS - 1)) begin
               state_in = svpw_pkg::ST_IDLE;
            end
         end
         svpw_pkg::ST_MUL_X: begin
            ix_in    = product[svpw_pkg::PROD_W-1:FW];
            fx_in    = product[FW-1:0];
            state_in = svpw_pkg::ST_MUL_Y;
         end
         svpw_pkg::ST_MUL_Y: begin
            iy_in    = product[svpw_pkg::PROD_W-1:FW];
            fy_in    = product[FW-1:0];
            state_in = svpw_pkg::ST_MUL_Z;
         end
         svpw_pkg::ST_MUL_Z: begin
            iz_in    = product[svpw_pkg::PROD_W-1:FW];
            fz_in    = product[FW-1:0];
            state_in = svpw_pkg::ST_GRID;
         end
         svpw_pkg::ST_GRID: begin
            acc_in = product[CW-1:0];
            if (grid_bad) begin
               strobe_in      = 1'b1;
               page_out_in    = '0;
               cell_out_in    = '0;
               frac_x_in      = '0;
               frac_y_in      = '0;
               frac_z_in      = '0;
               level_out_in   = '0;
               was_new_out_in = 1'b0;
               over_in        = 1'b0;
               oor_in         = 1'b1;
               state_in       = svpw_pkg::ST_IDLE;
            end else begin
               state_in = svpw_pkg::ST_PAGE_X;
            end
         end
         svpw_pkg::ST_PAGE_X: begin
            acc_in   = product[CW-1:0];
            state_in = svpw_pkg::ST_LOOKUP;
         end
         svpw_pkg::ST_LOOKUP: begin
            if (acc_ff >= CW'(svpw_pkg::MAX_PAGES)) begin
               strobe_in      = 1'b1;
               page_out_in    = '0;
               cell_out_in    = '0;
               frac_x_in      = '0;
               frac_y_in      = '0;
               frac_z_in      = '0;
               level_out_in   = '0;
               was_new_out_in = 1'b0;
               over_in        = 1'b0;
               oor_in         = 1'b1;
               state_in       = svpw_pkg::ST_IDLE;
            end else begin
               slot_in    = svpw_pkg::SLOT_W'(acc_ff * svpw_pkg::PAGE_CELLS + cell_sum);
               was_new_in = !page_present_ff[page_idx];
               state_in   = svpw_pkg::ST_WRITE;
            end
         end
         svpw_pkg::ST_WRITE: begin
            page_present_in[page_idx] = 1'b1;
            strobe_in      = 1'b1;
            page_out_in    = page_idx;
            cell_out_in    = cell_sum[svpw_pkg::CELL_W-1:0];
            frac_x_in      = svpw_pkg::frac_quant(fx_ff);
            frac_y_in      = svpw_pkg::frac_quant(fy_ff);
            frac_z_in      = svpw_pkg::frac_quant(fz_ff);
            level_out_in   = level_ff;
            was_new_out_in = was_new_ff;
            over_in        = written_rd_ff
                             && (store_rd_ff[svpw_pkg::STORE_W-1 -: svpw_pkg::LEVEL_W] != '0);
            oor_in         = 1'b0;
            state_in       = svpw_pkg::ST_IDLE;
         end
         default: begin
            state_in = svpw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= svpw_pkg::ST_CLEAR;
         clear_cnt_ff    <= '0;
         page_present_ff <= '0;
         strobe_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_cnt_ff    <= clear_cnt_in;
         page_present_ff <= page_present_in;
         strobe_ff       <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         scale_ff    <= svpw_pkg::SCALE_W'(256);
         pages_x_ff  <= svpw_pkg::GRID_W'(4);
         pages_y_ff  <= svpw_pkg::GRID_W'(4);
         pages_z_ff  <= svpw_pkg::GRID_W'(4);
      end else if (csr_wen) begin
         unique case (csr_index)
            svpw_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            svpw_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            svpw_pkg::CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            svpw_pkg::CSR_SCALE:    scale_ff    <= csr_wdata[svpw_pkg::SCALE_W-1:0];
            svpw_pkg::CSR_PAGES_X:  pages_x_ff  <= csr_wdata[svpw_pkg::GRID_W-1:0];
            svpw_pkg::CSR_PAGES_Y:  pages_y_ff  <= csr_wdata[svpw_pkg::GRID_W-1:0];
            svpw_pkg::CSR_PAGES_Z:  pages_z_ff  <= csr_wdata[svpw_pkg::GRID_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      diff_x_ff      <= diff_x_in;
      diff_y_ff      <= diff_y_in;
      diff_z_ff      <= diff_z_in;
      neg_ff         <= neg_in;
      level_ff       <= level_in;
      ix_ff          <= ix_in;
      iy_ff          <= iy_in;
      iz_ff          <= iz_in;
      fx_ff          <= fx_in;
      fy_ff          <= fy_in;
      fz_ff          <= fz_in;
      acc_ff         <= acc_in;
      slot_ff        <= slot_in;
      was_new_ff     <= was_new_in;
      page_out_ff    <= page_out_in;
      cell_out_ff    <= cell_out_in;
      frac_x_ff      <= frac_x_in;
      frac_y_ff      <= frac_y_in;
      frac_z_ff      <= frac_z_in;
      level_out_ff   <= level_out_in;
      was_new_out_ff <= was_new_out_in;
      over_ff        <= over_in;
      oor_ff         <= oor_in;
   end

   // cell memories: read in lookup, written in write, flag memory swept after reset
   always_ff @(posedge clock) begin
      if (state_ff == svpw_pkg::ST_LOOKUP) begin
         written_rd_ff <= cell_written_mem[slot_in];
         store_rd_ff   <= cell_store_mem[slot_in];
      end
      if (state_ff == svpw_pkg::ST_CLEAR) begin
         cell_written_mem[clear_cnt_ff] <= 1'b0;
      end else if (state_ff == svpw_pkg::ST_WRITE) begin
         cell_written_mem[slot_ff] <= 1'b1;
      end
      if (state_ff == svpw_pkg::ST_WRITE) begin
         cell_store_mem[slot_ff] <= {level_ff, frac_z_in, frac_y_in, frac_x_in};
      end
   end

   assign busy             = (state_ff != svpw_pkg::ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_page_number  = page_out_ff;
   assign rsp_cell_number  = cell_out_ff;
   assign rsp_frac_x       = frac_x_ff;
   assign rsp_frac_y       = frac_y_ff;
   assign rsp_frac_z       = frac_z_ff;
   assign rsp_stored_level = level_out_ff;
   assign rsp_page_was_new = was_new_out_ff;
   assign rsp_overwrote    = over_ff;
   assign rsp_out_of_range = oor_ff;

   // a fresh page cannot hold an occupied cell
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_overwrote |-> !rsp_page_was_new)
      else $error("overwrite reported on a newly allocated page");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_of_range |-> rsp_page_number == '0 && rsp_cell_number == '0
         && rsp_stored_level == '0 && !rsp_page_was_new && !rsp_overwrote)
      else $error("dropped point carries nonzero result fields");

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("accepted transfer did not start the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   assert property (@(posedge clock)
      $past(reset) && !reset |-> busy && !rsp_strobe)
      else $error("block not sweeping the cell memory after reset");

endmodule

// ----- sim/sparse_volume_point_writer_tb.sv -----
`timescale 1ns / 100ps

module sparse_volume_point_writer_tb;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam logic [svpw_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int SCALE_PAD = svpw_pkg::CSR_DATA_W - svpw_pkg::SCALE_W;
   localparam int GRID_PAD = svpw_pkg::CSR_DATA_W - svpw_pkg::GRID_W;
   localparam longint COORD_MAX = (longint'(1) <<< (svpw_pkg::COORD_W - 1)) - 1;

   typedef logic signed [svpw_pkg::COORD_W-1:0] point_type [3];

   typedef struct packed {
      logic [svpw_pkg::PAGE_W-1:0]  page_number;
      logic [svpw_pkg::CELL_W-1:0]  cell_number;
      logic [svpw_pkg::FRAC_W-1:0]  frac_x;
      logic [svpw_pkg::FRAC_W-1:0]  frac_y;
      logic [svpw_pkg::FRAC_W-1:0]  frac_z;
      logic [svpw_pkg::LEVEL_W-1:0] stored_level;
      logic                         page_was_new;
      logic                         overwrote;
      logic                         out_of_range;
   } cell_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [svpw_pkg::COORD_W-1:0] req_point_x = '0;
   logic signed [svpw_pkg::COORD_W-1:0] req_point_y = '0;
   logic signed [svpw_pkg::COORD_W-1:0] req_point_z = '0;
   logic [svpw_pkg::LEVEL_W-1:0] req_level = '0;
   logic rsp_strobe;
   logic [svpw_pkg::PAGE_W-1:0] rsp_page_number;
   logic [svpw_pkg::CELL_W-1:0] rsp_cell_number;
   logic [svpw_pkg::FRAC_W-1:0] rsp_frac_x;
   logic [svpw_pkg::FRAC_W-1:0] rsp_frac_y;
   logic [svpw_pkg::FRAC_W-1:0] rsp_frac_z;
   logic [svpw_pkg::LEVEL_W-1:0] rsp_stored_level;
   logic rsp_page_was_new;
   logic rsp_overwrote;
   logic rsp_out_of_range;
   logic csr_wen = 1'b0;
   logic [svpw_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [svpw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // mirror of the block's registers and memories
   longint origin_q8 [3] = '{0, 0, 0};
   longint cells_per_unit = 256;
   longint grid_pages [3] = '{4, 4, 4};
   bit page_mapped [svpw_pkg::MAX_PAGES];
   bit cell_filled [svpw_pkg::TOTAL_CELLS];
   bit [svpw_pkg::LEVEL_W-1:0] cell_level [svpw_pkg::TOTAL_CELLS];

   cell_result_type expected_writes [$];

   int unsigned idle_pct = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned points_sent = 0;
   int unsigned drops_seen = 0;
   int unsigned new_pages_seen = 0;
   int unsigned overwrites_seen = 0;
   int unsigned settings_used = 0;

   sparse_volume_point_writer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_level        (req_level),
      .rsp_strobe       (rsp_strobe),
      .rsp_page_number  (rsp_page_number),
      .rsp_cell_number  (rsp_cell_number),
      .rsp_frac_x       (rsp_frac_x),
      .rsp_frac_y       (rsp_frac_y),
      .rsp_frac_z       (rsp_frac_z),
      .rsp_stored_level (rsp_stored_level),
      .rsp_page_was_new (rsp_page_was_new),
      .rsp_overwrote    (rsp_overwrote),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic cell_result_type map_point(input point_type pt,
                                                 input logic [svpw_pkg::LEVEL_W-1:0] lvl);
      cell_result_type r;
      longint pos [3];
      longint whole [3];
      longint page_idx, cell_idx, slot;
      int a;
      r = '0;
      for (a = 0; a < 3; a++) begin
         if (longint'(pt[a]) - origin_q8[a] < 0)
            r.out_of_range = 1'b1;
         pos[a] = (longint'(pt[a]) - origin_q8[a]) * cells_per_unit;
         whole[a] = pos[a] >>> 16;
      end
      if (r.out_of_range)
         return r;
      if ((whole[0] / svpw_pkg::PAGE_DIM_X) >= grid_pages[0] ||
          (whole[1] / svpw_pkg::PAGE_DIM_Y) >= grid_pages[1] ||
          (whole[2] / svpw_pkg::PAGE_DIM_Z) >= grid_pages[2]) begin
         r.out_of_range = 1'b1;
         return r;
      end
      page_idx = (whole[0] / svpw_pkg::PAGE_DIM_X) +
                 (whole[1] / svpw_pkg::PAGE_DIM_Y) * grid_pages[0] +
                 (whole[2] / svpw_pkg::PAGE_DIM_Z) * grid_pages[0] * grid_pages[1];
      if (page_idx >= svpw_pkg::MAX_PAGES) begin
         r.out_of_range = 1'b1;
         return r;
      end
      cell_idx = (whole[0] % svpw_pkg::PAGE_DIM_X) +
                 (whole[1] % svpw_pkg::PAGE_DIM_Y) * svpw_pkg::PAGE_DIM_X +
                 (whole[2] % svpw_pkg::PAGE_DIM_Z) * svpw_pkg::PAGE_DIM_X * svpw_pkg::PAGE_DIM_Y;
      slot = page_idx * svpw_pkg::PAGE_CELLS + cell_idx;
      r.page_number = svpw_pkg::PAGE_W'(page_idx);
      r.cell_number = svpw_pkg::CELL_W'(cell_idx);
      r.frac_x = svpw_pkg::FRAC_W'(((pos[0] & 'hFFFF) * 255) >> 16);
      r.frac_y = svpw_pkg::FRAC_W'(((pos[1] & 'hFFFF) * 255) >> 16);
      r.frac_z = svpw_pkg::FRAC_W'(((pos[2] & 'hFFFF) * 255) >> 16);
      r.stored_level = lvl;
      r.page_was_new = !page_mapped[page_idx];
      r.overwrote = cell_filled[slot] && cell_level[slot] != 0;
      page_mapped[page_idx] = 1'b1;
      cell_filled[slot] = 1'b1;
      cell_level[slot] = lvl;
      return r;
   endfunction

   // coordinate that lands somewhere in the first cells along one axis
   function automatic logic signed [svpw_pkg::COORD_W-1:0] aim_axis(input int a,
                                                                     input int unsigned cells);
      longint target, offset, pt;
      target = (longint'($urandom_range(cells - 1)) <<< 16) + $urandom_range(16'hFFFF);
      if (cells_per_unit == 0)
         offset = longint'($urandom_range(1023));
      else
         offset = target / cells_per_unit;
      pt = origin_q8[a] + offset;
      if (pt > COORD_MAX)
         pt = COORD_MAX;
      return svpw_pkg::COORD_W'(pt);
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      cell_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_writes.size() == 0) begin
            $error("result transfer with no point outstanding");
            mismatch_count++;
         end else begin
            want = expected_writes.pop_front();
            drops_seen += want.out_of_range;
            new_pages_seen += want.page_was_new;
            overwrites_seen += want.overwrote;
            check_field("page_number", want.page_number, rsp_page_number);
            check_field("cell_number", want.cell_number, rsp_cell_number);
            check_field("frac_x", want.frac_x, rsp_frac_x);
            check_field("frac_y", want.frac_y, rsp_frac_y);
            check_field("frac_z", want.frac_z, rsp_frac_z);
            check_field("stored_level", want.stored_level, rsp_stored_level);
            check_field("page_was_new", want.page_was_new, rsp_page_was_new);
            check_field("overwrote", want.overwrote, rsp_overwrote);
            check_field("out_of_range", want.out_of_range, rsp_out_of_range);
         end
      end
   end

   task automatic send_point(input point_type pt, input logic [svpw_pkg::LEVEL_W-1:0] lvl);
      forever begin
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_point_x <= pt[0];
            req_point_y <= pt[1];
            req_point_z <= pt[2];
            req_level <= lvl;
         end
         @(posedge clock);
         if (start && busy === 1'b0)
            break;
      end
      expected_writes.insert(expected_writes.size(), map_point(pt, lvl));
      points_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_writes.size() != 0)
         @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [svpw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [svpw_pkg::CSR_DATA_W-1:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         svpw_pkg::CSR_ORIGIN_X: origin_q8[0] = longint'($signed(value));
         svpw_pkg::CSR_ORIGIN_Y: origin_q8[1] = longint'($signed(value));
         svpw_pkg::CSR_ORIGIN_Z: origin_q8[2] = longint'($signed(value));
         svpw_pkg::CSR_SCALE:    cells_per_unit = longint'(value[svpw_pkg::SCALE_W-1:0]);
         svpw_pkg::CSR_PAGES_X:  grid_pages[0] = longint'(value[svpw_pkg::GRID_W-1:0]);
         svpw_pkg::CSR_PAGES_Y:  grid_pages[1] = longint'(value[svpw_pkg::GRID_W-1:0]);
         svpw_pkg::CSR_PAGES_Z:  grid_pages[2] = longint'(value[svpw_pkg::GRID_W-1:0]);
         default: ;
      endcase
   endtask

   // unused upper data bits carry noise on the narrow registers
   task automatic configure(input longint ox, input longint oy, input longint oz,
                            input longint scale, input longint gx, input longint gy,
                            input longint gz);
      wait_idle();
      write_reg(svpw_pkg::CSR_ORIGIN_X, svpw_pkg::CSR_DATA_W'(ox));
      write_reg(svpw_pkg::CSR_ORIGIN_Y, svpw_pkg::CSR_DATA_W'(oy));
      write_reg(svpw_pkg::CSR_ORIGIN_Z, svpw_pkg::CSR_DATA_W'(oz));
      write_reg(svpw_pkg::CSR_SCALE, {SCALE_PAD'($urandom), svpw_pkg::SCALE_W'(scale)});
      write_reg(svpw_pkg::CSR_PAGES_X, {GRID_PAD'($urandom), svpw_pkg::GRID_W'(gx)});
      write_reg(svpw_pkg::CSR_PAGES_Y, {GRID_PAD'($urandom), svpw_pkg::GRID_W'(gy)});
      write_reg(svpw_pkg::CSR_PAGES_Z, {GRID_PAD'($urandom), svpw_pkg::GRID_W'(gz)});
      settings_used++;
   endtask

   task automatic test_reset_defaults();
      send_point('{0, 0, 0}, 8'hFF);
      send_point('{0, 0, 0}, 8'h00);
      send_point('{0, 0, 0}, 8'h07);
      send_point('{128, 64, 1}, 8'h01);
      send_point('{8191, 8191, 8191}, 8'h80);
      send_point('{8388607, 8388607, 8388607}, 8'hAA);
      send_point('{-8388608, -8388608, -8388608}, 8'h55);
      send_point('{-1, 0, 0}, 8'h10);
      send_point('{0, -1, 0}, 8'h20);
      send_point('{0, 0, -1}, 8'h40);
      send_point('{8192, 0, 0}, 8'h02);
      send_point('{0, 8192, 0}, 8'h04);
      send_point('{0, 0, 8192}, 8'h08);
   endtask

   task automatic test_unknown_register();
      wait_idle();
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      send_point('{256, 256, 256}, 8'h3C);
   endtask

   task automatic test_zero_scale();
      configure(0, 0, 0, 0, 4, 4, 4);
      send_point('{8388607, 1234, 77}, 8'h11);
      send_point('{0, 0, -5}, 8'h22);
   endtask

   task automatic test_zero_grid();
      configure(0, 0, 0, 256, 0, 4, 4);
      send_point('{0, 0, 0}, 8'h33);
      configure(0, 0, 0, 256, 4, 4, 0);
      send_point('{0, 0, 0}, 8'h44);
   endtask

   task automatic test_page_overflow();
      configure(0, 0, 0, 256, 64, 64, 64);
      send_point('{0, 2048, 0}, 8'h66);
      send_point('{129024, 0, 0}, 8'h77);
      send_point('{131072, 0, 0}, 8'h88);
   endtask

   task automatic test_register_extremes();
      configure(-8388608, -8388608, -8388608, 65535, 127, 127, 127);
      send_point('{-8388608, -8388608, -8388608}, 8'h99);
      send_point('{-8388607, -8388608, -8388608}, 8'hFE);
      send_point('{8388607, 8388607, 8388607}, 8'hEE);
      configure(8388607, 8388607, 8388607, 1, 1, 1, 1);
      send_point('{8388607, 8388607, 8388607}, 8'hDD);
      send_point('{0, 0, 0}, 8'hCC);
   endtask

   // mostly aimed at the grid, some at a small hot corner, some past the edge, some noise
   task automatic scatter_points(input int unsigned count);
      point_type pt;
      int unsigned pick, extent;
      int a;
      logic [svpw_pkg::LEVEL_W-1:0] lvl;
      repeat (count) begin
         pick = $urandom_range(99);
         for (a = 0; a < 3; a++) begin
            extent = (grid_pages[a] == 0) ? 1 : int'(grid_pages[a]) *
                     ((a == 0) ? svpw_pkg::PAGE_DIM_X :
                      (a == 1) ? svpw_pkg::PAGE_DIM_Y : svpw_pkg::PAGE_DIM_Z);
            if (pick < 55)
               pt[a] = aim_axis(a, extent);
            else if (pick < 80)
               pt[a] = aim_axis(a, 3);
            else if (pick < 90)
               pt[a] = aim_axis(a, extent + 12);
            else
               pt[a] = svpw_pkg::COORD_W'($urandom);
         end
         lvl = ($urandom_range(7) == 0) ? '0 : svpw_pkg::LEVEL_W'($urandom);
         send_point(pt, lvl);
      end
   endtask

   task automatic test_random_scatter();
      idle_pct = 31;
      configure(0, 0, 0, 256, 4, 4, 4);
      scatter_points(285);
      configure(longint'($urandom_range(2097152)) - 1048576,
                longint'($urandom_range(2097152)) - 1048576,
                longint'($urandom_range(2097152)) - 1048576, 1000, 8, 4, 2);
      scatter_points(285);
      idle_pct = 48;
      configure(longint'($urandom_range(65536)) - 32768, -300, 4096, 128, 16, 16, 16);
      scatter_points(285);
      configure(-1000, longint'($urandom_range(20000)), 5, 65535, 1, 1, 1);
      scatter_points(285);
      idle_pct = 0;
      configure(-8388608, -8388608, -8388608, 1, 127, 127, 127);
      scatter_points(285);
      configure(longint'($urandom_range(4194304)) - 2097152,
                longint'($urandom_range(4194304)) - 2097152,
                longint'($urandom_range(4194304)) - 2097152,
                $urandom_range(1, 65535), $urandom_range(1, 8), $urandom_range(1, 8),
                $urandom_range(1, 4));
      scatter_points(285);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      wait_idle();
      idle_pct = 31;
      test_reset_defaults();
      test_unknown_register();
      test_zero_scale();
      test_zero_grid();
      test_page_overflow();
      test_register_extremes();
      test_random_scatter();
      wait_idle();
      $display("%0d points over %0d register settings: %0d dropped, %0d pages first touched,",
               points_sent, settings_used + 1, drops_seen, new_pages_seen);
      $display("%0d occupied cells overwritten", overwrites_seen);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
